FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define NPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/npc_pkg.sv
package npc_pkg;

  localparam int PALETTE_DEPTH = 64;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int CH_W          = 8;
  localparam int SQ_W          = 16;
  localparam int TERM_W        = 18;
  localparam int DIST_W        = 20;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [9:0]        RED_BASE  = 10'd512;
  localparam logic [9:0]        BLUE_BASE = 10'd767;
  localparam logic [DIST_W-1:0] DIST_INIT = '1;
  localparam logic [DIST_W-1:0] DIST_MAX  = 20'd600000;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd1;
  localparam logic [CNT_W-1:0] COUNT_MIN   = 7'd1;
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(PALETTE_DEPTH);

  typedef struct packed {
    logic            command;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  tag;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [CH_W-1:0]   best_tag;
    logic [DIST_W-1:0] best_distance;
  } out_resp_t;

  // One slot of the chain: the request plus the running best match.
  typedef struct packed {
    logic              valid;
    in_req_t           req;
    logic [IDX_W-1:0]  best_index;
    logic [CH_W-1:0]   best_tag;
    logic [DIST_W-1:0] best_distance;
  } item_t;

endpackage

FILE: rtl/npc_cell.sv
`include "assert_macros.svh"

module npc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic [npc_pkg::IDX_W-1:0] cell_index,
  input  logic [npc_pkg::CNT_W-1:0] count_eff,
  input  npc_pkg::item_t           in_item,
  output npc_pkg::item_t           out_item
);

  // Palette entry held by this cell.
  logic [npc_pkg::CH_W-1:0] ent_red_r, ent_green_r, ent_blue_r, ent_tag_r;

  // Stage 1: squared channel differences and the mean red.
  npc_pkg::item_t           s1_item_r;
  logic [npc_pkg::SQ_W-1:0] s1_dr2_r, s1_dg2_r, s1_db2_r;
  logic [npc_pkg::CH_W-1:0] s1_m_r, s1_tag_r;
  // Stage 2: weighted terms.
  npc_pkg::item_t             s2_item_r;
  logic [npc_pkg::TERM_W-1:0] s2_tr_r, s2_tg_r, s2_tb_r;
  logic [npc_pkg::CH_W-1:0]   s2_tag_r;
  // Stage 3: compare and update the running best.
  npc_pkg::item_t s3_item_r;

  logic                     wr_hit;
  logic [npc_pkg::CH_W:0]   red_sum;
  logic [npc_pkg::CH_W-1:0] dr, dg, db;
  logic [9:0]               red_w, blue_w;
  logic [25:0]              tr_full, tb_full;
  logic [npc_pkg::DIST_W-1:0] cand_dist;
  logic                     cell_active;
  logic                     take;
  npc_pkg::item_t           s3_item_nxt;

  assign wr_hit = in_item.valid && (in_item.req.command == npc_pkg::CMD_WRITE) &&
                  (in_item.req.entry_index == cell_index);

  always_ff @(posedge clk) begin
    if (adv && wr_hit) begin
      ent_red_r   <= in_item.req.red;
      ent_green_r <= in_item.req.green;
      ent_blue_r  <= in_item.req.blue;
      ent_tag_r   <= in_item.req.tag;
    end
  end

  always_comb begin
    red_sum = {1'b0, in_item.req.red} + {1'b0, ent_red_r};
    dr = (in_item.req.red > ent_red_r) ? in_item.req.red - ent_red_r
                                       : ent_red_r - in_item.req.red;
    dg = (in_item.req.green > ent_green_r) ? in_item.req.green - ent_green_r
                                           : ent_green_r - in_item.req.green;
    db = (in_item.req.blue > ent_blue_r) ? in_item.req.blue - ent_blue_r
                                         : ent_blue_r - in_item.req.blue;
  end

  always_comb begin
    red_w   = npc_pkg::RED_BASE + {2'b00, s1_m_r};
    blue_w  = npc_pkg::BLUE_BASE - {2'b00, s1_m_r};
    tr_full = red_w * s1_dr2_r;
    tb_full = blue_w * s1_db2_r;
  end

  always_comb begin
    cand_dist = npc_pkg::DIST_W'(s2_tr_r) + npc_pkg::DIST_W'(s2_tg_r) +
                npc_pkg::DIST_W'(s2_tb_r);
    cell_active = {1'b0, cell_index} < count_eff;
    // Strict less keeps the lowest index on a tie.
    take = s2_item_r.valid && (s2_item_r.req.command == npc_pkg::CMD_PIXEL) &&
           cell_active && (cand_dist < s2_item_r.best_distance);
    s3_item_nxt = s2_item_r;
    if (take) begin
      s3_item_nxt.best_distance = cand_dist;
      s3_item_nxt.best_index    = cell_index;
      s3_item_nxt.best_tag      = s2_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r.req           <= in_item.req;
      s1_item_r.best_index    <= in_item.best_index;
      s1_item_r.best_tag      <= in_item.best_tag;
      s1_item_r.best_distance <= in_item.best_distance;
      s1_dr2_r <= dr * dr;
      s1_dg2_r <= dg * dg;
      s1_db2_r <= db * db;
      s1_m_r   <= red_sum[npc_pkg::CH_W:1];
      s1_tag_r <= ent_tag_r;

      s2_item_r.req           <= s1_item_r.req;
      s2_item_r.best_index    <= s1_item_r.best_index;
      s2_item_r.best_tag      <= s1_item_r.best_tag;
      s2_item_r.best_distance <= s1_item_r.best_distance;
      s2_tr_r  <= tr_full[25:8];
      s2_tg_r  <= {s1_dg2_r, 2'b00};
      s2_tb_r  <= tb_full[25:8];
      s2_tag_r <= s1_tag_r;

      s3_item_r.req           <= s3_item_nxt.req;
      s3_item_r.best_index    <= s3_item_nxt.best_index;
      s3_item_r.best_tag      <= s3_item_nxt.best_tag;
      s3_item_r.best_distance <= s3_item_nxt.best_distance;
    end
    if (!rst_n) begin
      s1_item_r.valid <= 1'b0;
      s2_item_r.valid <= 1'b0;
      s3_item_r.valid <= 1'b0;
    end else if (adv) begin
      s1_item_r.valid <= in_item.valid;
      s2_item_r.valid <= s1_item_r.valid;
      s3_item_r.valid <= s3_item_nxt.valid;
    end
  end

  assign out_item = s3_item_r;

  // Entry zero always wins against the start value, so any active cell passes on a real distance.
  `NPC_ASSERT(a_cell_dist_range,
    (s3_item_r.valid && (s3_item_r.req.command == npc_pkg::CMD_PIXEL) &&
     ({1'b0, cell_index} < count_eff)) |-> (s3_item_r.best_distance <= npc_pkg::DIST_MAX),
    "active cell passed on a pixel without a valid distance")
  `NPC_ASSERT(a_cell_best_order,
    (s3_item_r.valid && (s3_item_r.req.command == npc_pkg::CMD_PIXEL)) |->
    (s3_item_r.best_index <= cell_index),
    "best index lies beyond the cell that carries it")
  `NPC_ASSERT_ALWAYS(a_cell_reset_valid, !rst_n |=> !s3_item_r.valid,
    "cell output valid after reset")

endmodule

FILE: rtl/nearest_palette_color_unit.sv
// Channel   Ports                        Direction  Content
// request   in_valid/in_ready/in_req     in         palette write or pixel
// result    out_valid/out_ready/out_resp out        index, tag, distance per pixel
// config    cfg_we/cfg_wdata             in         palette_count
//
// One request is accepted per cycle while the chain is not held; each of the 64 cells has
// three stages, so a pixel passes the s1, s2 and s3 registers of every cell in turn and
// then the output register, which loads when the pixel leaves the tail of the chain.
// Palette writes travel the same chain and keep order with pixels.
// Reset clears the valid bits and sets palette_count to 1; palette entries are not reset.
// The chain holds only while a pixel sits at its tail and the output register is not taken.

`include "assert_macros.svh"

module nearest_palette_color_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  npc_pkg::in_req_t          in_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output npc_pkg::out_resp_t        out_resp,
  input  logic                      cfg_we,
  input  logic [npc_pkg::CNT_W-1:0] cfg_wdata
);

  logic [npc_pkg::CNT_W-1:0] palette_count_r;
  logic [npc_pkg::CNT_W-1:0] count_eff;
  npc_pkg::item_t            chain [0:npc_pkg::PALETTE_DEPTH];
  npc_pkg::item_t            tail;
  logic                      tail_pixel;
  logic                      chain_adv;
  logic                      out_valid_r;
  npc_pkg::out_resp_t        out_resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_count_r <= npc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      palette_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (palette_count_r < npc_pkg::COUNT_MIN) begin
      count_eff = npc_pkg::COUNT_MIN;
    end else if (palette_count_r > npc_pkg::COUNT_MAX) begin
      count_eff = npc_pkg::COUNT_MAX;
    end else begin
      count_eff = palette_count_r;
    end
  end

  always_comb begin
    chain[0].valid         = in_valid;
    chain[0].req           = in_req;
    chain[0].best_index    = '0;
    chain[0].best_tag      = '0;
    chain[0].best_distance = npc_pkg::DIST_INIT;
  end

  for (genvar k = 0; k < npc_pkg::PALETTE_DEPTH; k++) begin : g_cell
    npc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (chain_adv),
      .cell_index (npc_pkg::IDX_W'(k)),
      .count_eff  (count_eff),
      .in_item    (chain[k]),
      .out_item   (chain[k+1])
    );
  end

  assign tail       = chain[npc_pkg::PALETTE_DEPTH];
  assign tail_pixel = tail.valid && (tail.req.command == npc_pkg::CMD_PIXEL);
  // Writes and bubbles leave the tail freely; only a pixel needs the output register.
  assign chain_adv  = !(tail_pixel && out_valid_r && !out_ready);
  assign in_ready   = chain_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (chain_adv && tail_pixel) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_adv && tail_pixel) begin
      out_resp_r.best_index    <= tail.best_index;
      out_resp_r.best_tag      <= tail.best_tag;
      out_resp_r.best_distance <= tail.best_distance;
    end
  end

  assign out_valid = out_valid_r;
  assign out_resp  = out_resp_r;

  `NPC_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r,
    "result valid after reset")
  `NPC_ASSERT(a_stall_cause, !chain_adv |-> (out_valid_r && !out_ready && tail_pixel),
    "chain held without a blocked result")
  `NPC_ASSERT(a_out_dist_range, out_valid_r |-> (out_resp_r.best_distance <= npc_pkg::DIST_MAX),
    "result distance out of range")
  `NPC_ASSERT(a_count_in_range,
    (count_eff >= npc_pkg::COUNT_MIN) && (count_eff <= npc_pkg::COUNT_MAX),
    "effective palette count outside the palette")

endmodule
